// ===== hdl/rmf_pkg.sv =====
// rmf_pkg: shared types and constants for the RGB 3x3 median filter.
// No dependencies; imported by every rmf_* module except rmf_ram, and the top level.
package rmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int POS_W = ((ROW_W > CFG_DATA_W) ? ROW_W : CFG_DATA_W) + 1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // stored pixel word: {active, blue, green, red}
    localparam int WORD_W = 25;
    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic       in_active;
        logic       flush;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } t_pix_out;

    // padded 3x3 window ready for a plain median-of-9, cell = dy*3+dx
    typedef struct packed {
        logic [8:0][23:0] px;
        logic             last;
    } t_win_rec;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } t_q_stat;

    typedef logic [8:0][7:0] t_nine;

endpackage

// ===== hdl/rmf_ram.sv =====
// rmf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/rmf_front.sv =====
// rmf_front: input side. Raster counters, config registers, line stores, window,
// edge masking and padding. Depends on rmf_pkg and rmf_ram.
module rmf_front import rmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_pix_in               i_in_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_q_stat               i_q_stat,
    output logic                  o_push,
    output t_win_rec              o_rec
);
    logic [CFG_DATA_W-1:0] r_cfg_w, r_cfg_h;
    logic [CFG_DATA_W-1:0] eff_w, eff_h;
    logic [COL_W-1:0]      r_col, n_col;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [POS_W-1:0]      cx, ry, wx, hx, ox, oy;
    logic                  have, last, accept;
    logic [2:0]            rowv, colv;
    t_word                 word;

    // second stage: line store data is back
    logic                  r_bv, r_b_have, r_b_last;
    logic [COL_W-1:0]      r_b_col;
    t_word                 r_b_word;
    logic [2:0]            r_b_rowv, r_b_colv;
    logic                  r_fwd;
    t_word                 r_fwd_up, r_fwd_lo;
    t_word                 up_dout, lo_dout, eff_up, eff_lo;

    t_word [2:0][2:0]      r_win, n_win;
    logic [3:0]            n_valid, n_zero, rank;
    t_win_rec              rec;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_DATA_W'(MAX_WIDTH);
            r_cfg_h <= CFG_DATA_W'(MAX_HEIGHT);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_w == '0)                          eff_w = CFG_DATA_W'(1);
        else if (r_cfg_w > CFG_DATA_W'(MAX_WIDTH))  eff_w = CFG_DATA_W'(MAX_WIDTH);
        else                                        eff_w = r_cfg_w;
        if (r_cfg_h == '0)                          eff_h = CFG_DATA_W'(1);
        else if (r_cfg_h > CFG_DATA_W'(MAX_HEIGHT)) eff_h = CFG_DATA_W'(MAX_HEIGHT);
        else                                        eff_h = r_cfg_h;
    end

    // the queue must hold the item in the second stage plus the new one
    assign o_in_ready = ({1'b0, i_q_stat.count} + (QCNT_W+1)'(r_bv))
                        < (QCNT_W+1)'(QDEPTH);
    assign accept = i_in_valid && o_in_ready;

    // position of the pixel that reaches the window centre with this item
    always_comb begin
        cx = POS_W'(r_col);
        ry = POS_W'(r_row);
        wx = POS_W'(eff_w);
        hx = POS_W'(eff_h);
        if (cx == '0) begin
            have = ry >= POS_W'(2);
            oy   = ry - POS_W'(2);
            ox   = wx - POS_W'(1);
        end else begin
            have = ry >= POS_W'(1);
            oy   = ry - POS_W'(1);
            ox   = cx - POS_W'(1);
        end
        have = have && (oy < hx) && (ox < wx);
        last = have && (oy == hx - POS_W'(1)) && (ox == wx - POS_W'(1));
        rowv = {(oy + POS_W'(1)) < hx, 1'b1, oy != '0};
        colv = {(ox + POS_W'(1)) < wx, 1'b1, ox != '0};

        if (last) begin
            n_col = '0;
            n_row = '0;
        end else if (cx + POS_W'(1) >= wx) begin
            n_col = '0;
            n_row = (ry >= hx + POS_W'(1)) ? '0 : ROW_W'(ry + POS_W'(1));
        end else begin
            n_col = COL_W'(cx + POS_W'(1));
            n_row = r_row;
        end

        if (i_in_data.flush) word = '0;
        else word = {i_in_data.in_active, i_in_data.in_blue,
                     i_in_data.in_green, i_in_data.in_red};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_bv  <= 1'b0;
        end else begin
            r_bv <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_col  <= r_col;
            r_b_word <= word;
            r_b_have <= have;
            r_b_last <= last;
            r_b_rowv <= rowv;
            r_b_colv <= colv;
            // same column written by the item ahead at this very edge
            r_fwd    <= r_bv && (r_b_col == r_col);
            r_fwd_up <= eff_lo;
            r_fwd_lo <= r_b_word;
        end
    end

    rmf_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (r_bv),
        .i_waddr (r_b_col),
        .i_wdata (eff_lo),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (up_dout)
    );

    rmf_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WIDTH)) u_lower (
        .i_clk   (i_clk),
        .i_we    (r_bv),
        .i_waddr (r_b_col),
        .i_wdata (r_b_word),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (lo_dout)
    );

    assign eff_up = r_fwd ? r_fwd_up : up_dout;
    assign eff_lo = r_fwd ? r_fwd_lo : lo_dout;

    always_comb begin
        for (int dy = 0; dy < 3; dy++) begin
            n_win[dy][0] = r_win[dy][1];
            n_win[dy][1] = r_win[dy][2];
        end
        n_win[0][2] = eff_up;
        n_win[1][2] = eff_lo;
        n_win[2][2] = r_b_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_bv) begin
            r_win <= n_win;
        end
    end

    // Cells outside the image are padded with 0 and 0xFF so that the middle
    // of nine lands on element count/2 of the valid values.
    always_comb begin
        n_valid = '0;
        for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
                n_valid = n_valid + 4'(r_b_rowv[dy] & r_b_colv[dx]);
            end
        end
        case (n_valid)
            4'd9:    n_zero = 4'd0;
            4'd6:    n_zero = 4'd1;
            4'd4:    n_zero = 4'd2;
            4'd3:    n_zero = 4'd3;
            4'd2:    n_zero = 4'd3;
            4'd1:    n_zero = 4'd4;
            default: n_zero = 4'd0;
        endcase
        rank = '0;
        for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
                if (!n_win[1][1][WORD_W-1]) begin
                    rec.px[dy*3+dx] = n_win[1][1][23:0];
                end else if (r_b_rowv[dy] && r_b_colv[dx]) begin
                    rec.px[dy*3+dx] = n_win[dy][dx][23:0];
                end else begin
                    rec.px[dy*3+dx] = (rank < n_zero) ? 24'h000000 : 24'hFFFFFF;
                    rank = rank + 4'd1;
                end
            end
        end
        rec.last = r_b_last;
    end

    assign o_push = r_bv && r_b_have;
    assign o_rec  = rec;
endmodule

// ===== hdl/rmf_queue.sv =====
// rmf_queue: short FIFO of padded windows between front and back.
// Depends on rmf_pkg.
module rmf_queue import rmf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_win_rec i_rec,
    input  logic     i_pop,
    output t_win_rec o_head,
    output t_q_stat  o_stat
);
    t_win_rec          r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_W'(1);
            if (i_pop)  r_rd <= r_rd + QPTR_W'(1);
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_rec;
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);
endmodule

// ===== hdl/rmf_back.sv =====
// rmf_back: three-stage median-of-9 sorting network per channel, output register.
// Depends on rmf_pkg.
module rmf_back import rmf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_win_rec i_head,
    input  t_q_stat  i_q_stat,
    output logic     o_pop,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_pix_out o_out_data
);
    function automatic t_nine cx(input t_nine p, input int a, input int b);
        t_nine q;
        q = p;
        if (p[a] > p[b]) begin
            q[a] = p[b];
            q[b] = p[a];
        end
        return q;
    endfunction

    function automatic t_nine layers_a(input t_nine p);
        t_nine q;
        q = p;
        q = cx(q, 1, 2); q = cx(q, 4, 5); q = cx(q, 7, 8);
        q = cx(q, 0, 1); q = cx(q, 3, 4); q = cx(q, 6, 7);
        q = cx(q, 1, 2); q = cx(q, 4, 5); q = cx(q, 7, 8);
        return q;
    endfunction

    function automatic t_nine layers_b(input t_nine p);
        t_nine q;
        q = p;
        q = cx(q, 0, 3); q = cx(q, 5, 8); q = cx(q, 4, 7);
        q = cx(q, 3, 6); q = cx(q, 1, 4); q = cx(q, 2, 5);
        q = cx(q, 4, 7);
        return q;
    endfunction

    function automatic t_nine layers_c(input t_nine p);
        t_nine q;
        q = p;
        q = cx(q, 4, 2); q = cx(q, 6, 4); q = cx(q, 4, 2);
        return q;
    endfunction

    logic          en;
    t_nine [2:0]   head_ch, s1_in, s2_in, s3_out;
    t_nine [2:0]   r_s1, r_s2;
    logic          r_v1, r_v2, r_l1, r_l2;
    logic          r_ov;
    t_pix_out      r_out;

    // whole back end moves together; stalls only when the output is held
    assign en    = !r_ov || i_out_ready;
    assign o_pop = en && !i_q_stat.empty;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 9; i++) begin
                head_ch[ch][i] = i_head.px[i][8*ch +: 8];
            end
            s1_in[ch]  = layers_a(head_ch[ch]);
            s2_in[ch]  = layers_b(r_s1[ch]);
            s3_out[ch] = layers_c(r_s2[ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1            <= s1_in;
            r_l1            <= i_head.last;
            r_s2            <= s2_in;
            r_l2            <= r_l1;
            r_out.out_red   <= s3_out[0][4];
            r_out.out_green <= s3_out[1][4];
            r_out.out_blue  <= s3_out[2][4];
            r_out.frame_end <= r_l2;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
endmodule

// ===== hdl/rgb_median_3x3_filter.sv =====
// rgb_median_3x3_filter: top level of the streaming RGB 3x3 median filter.
// Depends on rmf_pkg, rmf_front, rmf_queue, rmf_back.
//
// Takes one pixel per clock in raster order while o_in_ready is high, and
// returns each image pixel width+1 input transfers after it went in, so a
// frame needs width*height pixels followed by width+1 flush transfers. Sustained
// rate is one pixel per cycle while the output is not held: the line stores are
// dual-port RAMs with one read and one write per transfer, and the median is a
// 3-stage pipelined network. A completed window passes the second front stage,
// the queue, two network registers and the output register; output back-pressure
// fills the 4-entry queue, then holds o_in_ready low until the output moves again.
// Active pixels take the per-channel median of their valid neighbours (9, 6
// or 4 at interior, edge, corner); inactive pixels pass through. The line
// stores need no clearing after reset. Write width/height only while idle.
module rgb_median_3x3_filter import rmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_pix_in               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_pix_out              o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic     push, pop;
    t_win_rec rec, head;
    t_q_stat  q_stat;

    rmf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_rec       (rec)
    );

    rmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    rmf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );
endmodule

// ===== hdl/rmf_checker.sv =====
// rmf_checker: port-level assertions for rgb_median_3x3_filter, bound to the top.
// Depends on rmf_pkg.
module rmf_checker import rmf_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input t_pix_in               i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_pix_out              o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    a_in_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input transfer dropped or changed while waiting");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");
endmodule

bind rgb_median_3x3_filter rmf_checker u_rmf_checker (.*);
